// ===== hw/rtl/llsa_pkg.sv =====
package llsa_pkg;

    // field and register widths
    localparam int DELAY_BITS     = 36;
    localparam int COUNT_BITS     = 32;
    localparam int THRESH_BITS    = 36;
    localparam int OFFSET_BITS    = 27;
    localparam int SUM_BITS       = 64;
    localparam int SQSUM_BITS     = 64;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = THRESH_BITS;

    // register reset values
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 36'd15000000000;
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 27'd100000;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOSS_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET         = 8'd1;

    // ns to us: drop three bits, then divide by 125 through a reciprocal
    localparam int NS_SHIFT    = 3;
    localparam int NS_ODD      = 125;
    localparam int DIV_Y_BITS  = DELAY_BITS - NS_SHIFT;
    localparam int DIV_LO_BITS = (DIV_Y_BITS + 1) / 2;
    localparam int DIV_HI_BITS = DIV_Y_BITS - DIV_LO_BITS;
    localparam int RECIP_SHIFT = DIV_Y_BITS + 7;
    localparam int RECIP_BITS  = RECIP_SHIFT - 6;
    localparam int PROD_BITS   = DIV_Y_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((longint'(1) << RECIP_SHIFT) / NS_ODD + 1);

    // microsecond value, shifted value and its square
    localparam int Q_BITS     = DELAY_BITS - 9;
    localparam int SHIFT_BITS = ((Q_BITS > OFFSET_BITS) ? Q_BITS : OFFSET_BITS) + 1;
    localparam int SQ_BITS    = 2 * SHIFT_BITS;

    typedef struct packed {
        logic                  lost;
        logic [DELAY_BITS-1:0] delay;
        logic [SHIFT_BITS-1:0] shifted;
        logic [SQ_BITS-1:0]    sq;
    } scaled_t;

endpackage

// ===== hw/rtl/llsa_cfg_if.sv =====
interface llsa_cfg_if import llsa_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/llsa_in_if.sv =====
interface llsa_in_if import llsa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [DELAY_BITS-1:0] delay_ns;

    modport source (output valid, output mode, output delay_ns, input ready);
    modport sink (input valid, input mode, input delay_ns, output ready);
endinterface

// ===== hw/rtl/llsa_out_if.sv =====
interface llsa_out_if import llsa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] sample_count;
    logic [COUNT_BITS-1:0] loss_count;
    logic [DELAY_BITS-1:0] min_delay_ns;
    logic [DELAY_BITS-1:0] max_delay_ns;
    logic [SUM_BITS-1:0]   shifted_sum_us;
    logic [SQSUM_BITS-1:0] shifted_sum_sq;
    logic                  has_delay;

    modport source (output valid, output sample_count, output loss_count,
                    output min_delay_ns, output max_delay_ns, output shifted_sum_us,
                    output shifted_sum_sq, output has_delay, input ready);
    modport sink (input valid, input sample_count, input loss_count,
                  input min_delay_ns, input max_delay_ns, input shifted_sum_us,
                  input shifted_sum_sq, input has_delay, output ready);
endinterface

// ===== hw/rtl/llsa_scale.sv =====
module llsa_scale import llsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [THRESH_BITS-1:0] threshold,
    input  logic [OFFSET_BITS-1:0] offset,
    llsa_in_if.sink                sample_in,
    output logic                   item_valid,
    input  logic                   item_ready,
    output scaled_t                item
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: captured input
    logic                  mode1_reg;
    logic [DELAY_BITS-1:0] delay1_reg;

    // stage 2: loss decision and reciprocal partial products
    logic                                lost2_reg;
    logic [DELAY_BITS-1:0]               delay2_reg;
    logic [DIV_LO_BITS+RECIP_BITS-1:0]   plo2_reg;
    logic [DIV_HI_BITS+RECIP_BITS-1:0]   phi2_reg;

    // stage 3: shifted microseconds
    logic                  lost3_reg;
    logic [DELAY_BITS-1:0] delay3_reg;
    logic [SHIFT_BITS-1:0] shifted3_reg;

    // stage 4: square
    scaled_t item_reg;

    logic [DIV_Y_BITS-1:0]             div_y;
    logic [DIV_LO_BITS+RECIP_BITS-1:0] plo;
    logic [DIV_HI_BITS+RECIP_BITS-1:0] phi;
    logic                              lost1;
    logic [PROD_BITS-1:0]              prod;
    logic [Q_BITS-1:0]                 quot_us;
    logic [SHIFT_BITS-1:0]             shifted;
    logic signed [SQ_BITS-1:0]         sq;

    assign rdy4 = !v4_reg || item_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign sample_in.ready = rdy1;

    assign lost1 = mode1_reg || (delay1_reg > threshold);
    assign div_y = delay1_reg[DELAY_BITS-1:NS_SHIFT];
    assign plo   = div_y[DIV_LO_BITS-1:0] * RECIP;
    assign phi   = div_y[DIV_Y_BITS-1:DIV_LO_BITS] * RECIP;

    assign prod    = {phi2_reg, {DIV_LO_BITS{1'b0}}}
                   + {{(PROD_BITS-DIV_LO_BITS-RECIP_BITS){1'b0}}, plo2_reg};
    assign quot_us = prod[RECIP_SHIFT +: Q_BITS];
    assign shifted = {{(SHIFT_BITS-Q_BITS){1'b0}}, quot_us}
                   - {{(SHIFT_BITS-OFFSET_BITS){1'b0}}, offset};

    assign sq = $signed(shifted3_reg) * $signed(shifted3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= sample_in.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && sample_in.valid)
        begin
            mode1_reg  <= sample_in.mode;
            delay1_reg <= sample_in.delay_ns;
        end
        if (rdy2 && v1_reg)
        begin
            lost2_reg  <= lost1;
            delay2_reg <= delay1_reg;
            plo2_reg   <= plo;
            phi2_reg   <= phi;
        end
        if (rdy3 && v2_reg)
        begin
            lost3_reg    <= lost2_reg;
            delay3_reg   <= delay2_reg;
            shifted3_reg <= shifted;
        end
        if (rdy4 && v3_reg)
        begin
            item_reg.lost    <= lost3_reg;
            item_reg.delay   <= delay3_reg;
            item_reg.shifted <= shifted3_reg;
            item_reg.sq      <= sq;
        end
    end

    assign item_valid = v4_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/llsa_accum.sv =====
module llsa_accum import llsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  scaled_t      item,
    llsa_out_if.source   result_out
);

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [COUNT_BITS-1:0] lost_reg, lost_next;
    logic [DELAY_BITS-1:0] least_reg, least_next;
    logic [DELAY_BITS-1:0] greatest_reg, greatest_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [SQSUM_BITS-1:0] sqsum_reg, sqsum_next;

    logic                  take;
    logic [SUM_BITS-1:0]   shift_ext;
    logic [SUM_BITS-1:0]   sum_add;
    logic                  sum_ovf;
    logic [SQSUM_BITS:0]   sqsum_add;

    assign item_ready = !out_valid_reg || result_out.ready;
    assign take       = item_valid && item_ready;

    assign shift_ext = {{(SUM_BITS-SHIFT_BITS){item.shifted[SHIFT_BITS-1]}}, item.shifted};
    assign sum_add   = sum_reg + shift_ext;
    // same operand signs, different result sign
    assign sum_ovf   = (sum_reg[SUM_BITS-1] == shift_ext[SUM_BITS-1])
                    && (sum_add[SUM_BITS-1] != sum_reg[SUM_BITS-1]);
    assign sqsum_add = {1'b0, sqsum_reg} + {{(SQSUM_BITS+1-SQ_BITS){1'b0}}, item.sq};

    always_comb
    begin
        total_next    = (&total_reg) ? total_reg : total_reg + 1'b1;
        lost_next     = lost_reg;
        least_next    = least_reg;
        greatest_next = greatest_reg;
        sum_next      = sum_reg;
        sqsum_next    = sqsum_reg;
        if (item.lost)
        begin
            lost_next = (&lost_reg) ? lost_reg : lost_reg + 1'b1;
        end
        else
        begin
            // no maximum recorded yet: load both
            if (greatest_reg == '0)
            begin
                least_next    = item.delay;
                greatest_next = item.delay;
            end
            else
            begin
                if (item.delay < least_reg)
                begin
                    least_next = item.delay;
                end
                if (item.delay > greatest_reg)
                begin
                    greatest_next = item.delay;
                end
            end
            if (sum_ovf)
            begin
                sum_next = shift_ext[SUM_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                                 : {1'b0, {(SUM_BITS-1){1'b1}}};
            end
            else
            begin
                sum_next = sum_add;
            end
            sqsum_next = sqsum_add[SQSUM_BITS] ? '1 : sqsum_add[SQSUM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            lost_reg      <= '0;
            least_reg     <= '0;
            greatest_reg  <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
            total_reg     <= total_next;
            lost_reg      <= lost_next;
            least_reg     <= least_next;
            greatest_reg  <= greatest_next;
            sum_reg       <= sum_next;
            sqsum_reg     <= sqsum_next;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.sample_count   = total_reg;
    assign result_out.loss_count     = lost_reg;
    assign result_out.min_delay_ns   = least_reg;
    assign result_out.max_delay_ns   = greatest_reg;
    assign result_out.shifted_sum_us = sum_reg;
    assign result_out.shifted_sum_sq = sqsum_reg;
    assign result_out.has_delay      = (total_reg != lost_reg);

endmodule

// ===== hw/rtl/latency_loss_stats_accumulator_top.sv =====
// path: an input passes through the scaling stages, then the accumulate stage registers the result
// throughput: one input transaction per cycle while result_out.ready holds, one result transaction per input
// the rate is set by the final accumulate stage, which closes its loop through its own registers
// reset: rst_n asynchronous, active low; clears all statistics and the pipeline,
// loss threshold returns to 15000000000 ns and offset to 100000 us
module latency_loss_stats_accumulator_top import llsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    llsa_cfg_if.sink   cfg,
    llsa_in_if.sink    sample_in,
    llsa_out_if.source result_out
);

    // configuration registers, always ready for a write transaction
    logic [THRESH_BITS-1:0] threshold_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    // handoff from the scaling pipeline to the accumulate stage
    logic    item_valid;
    logic    item_ready;
    scaled_t item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            offset_reg    <= OFFSET_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LOSS_THRESHOLD:
                begin
                    threshold_reg <= cfg.data[THRESH_BITS-1:0];
                end
                REG_OFFSET:
                begin
                    offset_reg <= cfg.data[OFFSET_BITS-1:0];
                end
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // four stages: capture, loss compare and reciprocal partial products,
    // product sum and offset subtract, square
    llsa_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (threshold_reg),
        .offset     (offset_reg),
        .sample_in  (sample_in),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // counters, min and max, saturating sums; the state is the result register
    llsa_accum u_accum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .result_out (result_out)
    );

`ifndef NO_ASSERTIONS
    // losses are a subset of samples
    a_loss_le_samples : assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.loss_count <= result_out.sample_count))
        else $error("loss count above sample count");

    // min and max stay ordered
    a_min_le_max : assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.min_delay_ns <= result_out.max_delay_ns))
        else $error("min delay above max delay");

    // each following result carries a new sample count unless saturated
    a_count_moves : assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.ready) |=>
            (!result_out.valid
             || (result_out.sample_count != $past(result_out.sample_count))
             || (&result_out.sample_count)))
        else $error("sample count did not advance");
`endif

endmodule
